>>> sv/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is asserted
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, masked while reset is asserted
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> sv/pms_pkg.sv
package pms_pkg;

    // Field widths
    localparam int FUNC_W   = 2;
    localparam int SAMPLE_W = 12;
    localparam int BYTE_W   = 8;
    localparam int PHASE_W  = 3;
    localparam int CHAR_W   = 7;
    localparam int CNT_W    = 16;
    localparam int PAIR_W   = 2 * SAMPLE_W;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SETTLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RELAY    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POLARIZE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PAIRS    = 3'd5;

    localparam logic [CNT_W-1:0] RST_SETTLE   = 16'd20;
    localparam logic [CNT_W-1:0] RST_RELAY    = 16'd200;
    localparam logic [CNT_W-1:0] RST_POLARIZE = 16'd6000;
    localparam logic [CNT_W-1:0] RST_RELEASE  = 16'd20;
    localparam logic [CNT_W-1:0] RST_SAMPLE   = 16'd10;
    localparam logic [CNT_W-1:0] RST_PAIRS    = 16'd10000;

    // Item kinds
    localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_BYTE   = 2'd2;

    localparam logic [BYTE_W-1:0] START_BYTE = 8'h53;
    localparam logic [CNT_W-1:0]  CNT_MAX    = 16'hFFFF;

    // Sequencer phases, as seen on the phase output
    localparam logic [PHASE_W-1:0] PH_IDLE     = 3'd0;
    localparam logic [PHASE_W-1:0] PH_SETTLE   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_RELAY    = 3'd2;
    localparam logic [PHASE_W-1:0] PH_POLARIZE = 3'd3;
    localparam logic [PHASE_W-1:0] PH_RELEASE  = 3'd4;
    localparam logic [PHASE_W-1:0] PH_WAIT     = 3'd5;
    localparam logic [PHASE_W-1:0] PH_SAMPLING = 3'd6;

    typedef struct packed {
        logic [4:0][CNT_W-1:0] wait_len;
        logic [CNT_W-1:0]      pair_count;
    } cfg_t;

    // One result bundle: status plus an optional packed sample pair
    typedef struct packed {
        logic               valid;
        logic [PHASE_W-1:0] phase;
        logic               pair;
        logic               done;
        logic [PAIR_W-1:0]  bits;
    } bundle_t;

    // Map a 6-bit code onto the standard base64 alphabet
    function automatic logic [CHAR_W-1:0] b64_char(input logic [5:0] code);
        logic [CHAR_W-1:0] c;
        begin
            c = {1'b0, code};
            if (code < 6'd26)
                b64_char = c + 7'd65;
            else if (code < 6'd52)
                b64_char = c + 7'd71;
            else if (code < 6'd62)
                b64_char = c - 7'd4;
            else if (code == 6'd62)
                b64_char = 7'd43;
            else
                b64_char = 7'd47;
        end
    endfunction

endpackage

>>> sv/pms_ifs.sv
interface pms_in_if;
    import pms_pkg::*;

    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [SAMPLE_W-1:0] sample;
    logic [BYTE_W-1:0]   rx_byte;

    modport source (output valid, func, sample, rx_byte, input ready);
    modport sink   (input valid, func, sample, rx_byte, output ready);
endinterface

interface pms_out_if;
    import pms_pkg::*;

    logic               valid;
    logic               ready;
    logic               relay_drive;
    logic               coil_drive;
    logic               sampling_on;
    logic [PHASE_W-1:0] phase;
    logic               char_valid;
    logic [CHAR_W-1:0]  tx_char;
    logic               last_of_run;
    logic               run_done;

    modport source (output valid, relay_drive, coil_drive, sampling_on, phase,
                    char_valid, tx_char, last_of_run, run_done, input ready);
    modport sink   (input valid, relay_drive, coil_drive, sampling_on, phase,
                    char_valid, tx_char, last_of_run, run_done, output ready);
endinterface

>>> sv/pms_cfg_regs.sv
module pms_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [pms_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pms_pkg::CFG_DATA_W-1:0]  cfg_data,
    output pms_pkg::cfg_t                   cfg
);
    import pms_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_SETTLE:   cfg_next.wait_len[0] = cfg_data;
                REG_RELAY:    cfg_next.wait_len[1] = cfg_data;
                REG_POLARIZE: cfg_next.wait_len[2] = cfg_data;
                REG_RELEASE:  cfg_next.wait_len[3] = cfg_data;
                REG_SAMPLE:   cfg_next.wait_len[4] = cfg_data;
                REG_PAIRS:    cfg_next.pair_count  = cfg_data;
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wait_len[0] <= RST_SETTLE;
            cfg_reg.wait_len[1] <= RST_RELAY;
            cfg_reg.wait_len[2] <= RST_POLARIZE;
            cfg_reg.wait_len[3] <= RST_RELEASE;
            cfg_reg.wait_len[4] <= RST_SAMPLE;
            cfg_reg.pair_count  <= RST_PAIRS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> sv/pms_core.sv
module pms_core (
    input  logic            clk,
    input  logic            rst_n,
    pms_in_if.sink          item,
    input  pms_pkg::cfg_t   cfg,
    input  logic            bundle_ready,
    output pms_pkg::bundle_t bundle
);
    import pms_pkg::*;

    // Input register
    logic                in_v_reg;
    logic [FUNC_W-1:0]   func_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [BYTE_W-1:0]   rx_reg;

    // Sequencer state
    logic [PHASE_W-1:0]  phase_reg, phase_next;
    logic [CNT_W-1:0]    tick_reg, tick_next;
    logic [SAMPLE_W-1:0] held_reg, held_next;
    logic                odd_reg, odd_next;
    logic [CNT_W-1:0]    pairs_reg, pairs_next;

    logic                advance;
    logic [CNT_W-1:0]    wait_len;
    logic [CNT_W-1:0]    tick_inc;
    logic [CNT_W-1:0]    pairs_inc;
    logic [CNT_W-1:0]    target;
    logic                pair_out;
    logic                done_out;

    assign advance    = in_v_reg && bundle_ready;
    assign item.ready = !in_v_reg || bundle_ready;

    // Hold the accepted word until the result stage takes its bundle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            in_v_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            func_reg   <= item.func;
            sample_reg <= item.sample;
            rx_reg     <= item.rx_byte;
        end
    end

    // Wait length of the current phase, zero acting as one
    always_comb
    begin
        case (phase_reg)
            PH_SETTLE:   wait_len = cfg.wait_len[0];
            PH_RELAY:    wait_len = cfg.wait_len[1];
            PH_POLARIZE: wait_len = cfg.wait_len[2];
            PH_RELEASE:  wait_len = cfg.wait_len[3];
            PH_WAIT:     wait_len = cfg.wait_len[4];
            default:     wait_len = 16'd1;
        endcase
        if (wait_len == '0)
            wait_len = 16'd1;
    end

    assign tick_inc  = (tick_reg == CNT_MAX) ? tick_reg : tick_reg + 16'd1;
    assign pairs_inc = pairs_reg + 16'd1;
    assign target    = (cfg.pair_count == '0) ? 16'd1 : cfg.pair_count;

    // Update the sequencer for one word
    always_comb
    begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        held_next  = held_reg;
        odd_next   = odd_reg;
        pairs_next = pairs_reg;
        pair_out   = 1'b0;
        done_out   = 1'b0;
        case (func_reg)
            FUNC_TICK:
            begin
                if (phase_reg >= PH_SETTLE && phase_reg <= PH_WAIT)
                begin
                    if (tick_inc >= wait_len)
                    begin
                        phase_next = phase_reg + 3'd1;
                        tick_next  = '0;
                    end
                    else
                    begin
                        tick_next = tick_inc;
                    end
                end
            end
            FUNC_SAMPLE:
            begin
                if (phase_reg == PH_SAMPLING)
                begin
                    if (!odd_reg)
                    begin
                        held_next = sample_reg;
                        odd_next  = 1'b1;
                    end
                    else
                    begin
                        pair_out   = 1'b1;
                        odd_next   = 1'b0;
                        pairs_next = pairs_inc;
                        if (pairs_inc >= target)
                        begin
                            done_out   = 1'b1;
                            phase_next = PH_IDLE;
                            pairs_next = '0;
                            tick_next  = '0;
                        end
                    end
                end
            end
            FUNC_BYTE:
            begin
                if (phase_reg == PH_IDLE && rx_reg == START_BYTE)
                begin
                    phase_next = PH_SETTLE;
                    tick_next  = '0;
                    held_next  = '0;
                    odd_next   = 1'b0;
                    pairs_next = '0;
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            tick_reg  <= '0;
            held_reg  <= '0;
            odd_reg   <= 1'b0;
            pairs_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            held_reg  <= held_next;
            odd_reg   <= odd_next;
            pairs_reg <= pairs_next;
        end
    end

    // Bundle offered to the result stage
    always_comb
    begin
        bundle.valid = in_v_reg;
        bundle.phase = phase_next;
        bundle.pair  = pair_out;
        bundle.done  = done_out;
        bundle.bits  = {held_reg, sample_reg};
    end

endmodule

>>> sv/pms_serial.sv
module pms_serial (
    input  logic              clk,
    input  logic              rst_n,
    input  pms_pkg::bundle_t  bundle,
    output logic              bundle_ready,
    pms_out_if.source         result
);
    import pms_pkg::*;

    bundle_t    res_reg;
    logic       busy_reg;
    logic [1:0] idx_reg;
    logic       last_now;
    logic [5:0] code;

    assign last_now     = !res_reg.pair || idx_reg == 2'd3;
    assign bundle_ready = !busy_reg || (result.ready && last_now);

    // Step through the words of the held bundle, reload on the last one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (bundle_ready)
        begin
            busy_reg <= bundle.valid;
            idx_reg  <= '0;
        end
        else if (result.ready)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bundle_ready && bundle.valid)
            res_reg <= bundle;
    end

    // Most significant six bits first
    always_comb
    begin
        case (idx_reg)
            2'd0:    code = res_reg.bits[23:18];
            2'd1:    code = res_reg.bits[17:12];
            2'd2:    code = res_reg.bits[11:6];
            default: code = res_reg.bits[5:0];
        endcase
    end

    assign result.valid       = busy_reg;
    assign result.relay_drive = res_reg.phase >= PH_RELAY && res_reg.phase <= PH_RELEASE;
    assign result.coil_drive  = res_reg.phase == PH_POLARIZE;
    assign result.sampling_on = res_reg.phase == PH_SAMPLING;
    assign result.phase       = res_reg.phase;
    assign result.char_valid  = res_reg.pair;
    assign result.tx_char     = res_reg.pair ? b64_char(code) : '0;
    assign result.last_of_run = last_now;
    assign result.run_done    = res_reg.done;

endmodule

>>> sv/precession_measure_sequencer_top.sv
// An accepted word is held in the input register of the core, then moves into
// the result register of the serialiser, from which it is offered as a result.
// Throughput: one word per cycle while results are taken; a word that completes
// a sample pair holds the result register for its four base64 characters.
// Reset (rst_n, asynchronous, active low): idle phase, counters and pipeline
// valid flags cleared; configuration registers return to their defaults.
module precession_measure_sequencer_top (
    input  logic                            clk,
    input  logic                            rst_n,
    pms_in_if.sink                          item,
    pms_out_if.source                       result,
    input  logic                            cfg_we,
    input  logic [pms_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pms_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import pms_pkg::*;

    cfg_t    cfg;
    bundle_t bundle;
    logic    bundle_ready;

    // Configuration registers
    pms_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Sequencer state update
    pms_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cfg          (cfg),
        .bundle_ready (bundle_ready),
        .bundle       (bundle)
    );

    // Result register and character serialiser
    pms_serial u_serial (
        .clk          (clk),
        .rst_n        (rst_n),
        .bundle       (bundle),
        .bundle_ready (bundle_ready),
        .result       (result)
    );

endmodule

>>> sv/pms_checker.sv
`include "assert_macros.svh"

module pms_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          res_valid,
    input logic                          res_ready,
    input logic                          relay_drive,
    input logic                          coil_drive,
    input logic                          sampling_on,
    input logic [pms_pkg::PHASE_W-1:0]   phase,
    input logic                          char_valid,
    input logic                          last_of_run,
    input logic                          run_done
);
    import pms_pkg::*;

    // A status word is always the only word of its item
    `ASSERT_IMP(a_status_last, clk, rst_n, res_valid && !char_valid, last_of_run)

    // Drive levels agree with the reported phase
    `ASSERT_IMP(a_drive_phase, clk, rst_n, res_valid,
        sampling_on == (phase == PH_SAMPLING) && (!coil_drive || relay_drive))

    // A finished run reports characters and the idle phase
    `ASSERT_IMP(a_done_idle, clk, rst_n, res_valid && run_done,
        char_valid && phase == PH_IDLE)

    // The characters of one pair follow without a gap
    `ASSERT_NEXT(a_chars_follow, clk, rst_n, res_valid && res_ready && !last_of_run,
        res_valid && char_valid)

endmodule

bind precession_measure_sequencer_top pms_checker u_pms_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid   (result.valid),
    .res_ready   (result.ready),
    .relay_drive (result.relay_drive),
    .coil_drive  (result.coil_drive),
    .sampling_on (result.sampling_on),
    .phase       (result.phase),
    .char_valid  (result.char_valid),
    .last_of_run (result.last_of_run),
    .run_done    (result.run_done)
);

>>> tb/tb_precession_measure_sequencer_top.sv
module tb_precession_measure_sequencer_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pms_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 4;
    localparam int SETTLE_CYCLES  = 6;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_SHARE   = 30;

    // Item kind the block has no use for
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    localparam logic [4:0][CFG_IDX_W-1:0] WAIT_REGS =
        {REG_SAMPLE, REG_RELEASE, REG_POLARIZE, REG_RELAY, REG_SETTLE};

    typedef struct packed {
        logic               relay_drive;
        logic               coil_drive;
        logic               sampling_on;
        logic [PHASE_W-1:0] phase;
        logic               char_valid;
        logic [CHAR_W-1:0]  tx_char;
        logic               last_of_run;
        logic               run_done;
    } seq_report_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  stall_req;

    pms_in_if  item_if ();
    pms_out_if result_if ();

    precession_measure_sequencer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_if),
        .result    (result_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Sequencer mirror: configuration and run state
    logic [CNT_W-1:0]    wait_len [5];
    logic [CNT_W-1:0]    run_pairs;
    logic [PHASE_W-1:0]  seq_phase;
    logic [CNT_W-1:0]    tick_cnt;
    logic [SAMPLE_W-1:0] first_half;
    logic                odd_half;
    logic [CNT_W-1:0]    pairs_taken;

    string       b64_table =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    seq_report_t due_reports [$];

    int mismatches;
    int busy_words;
    int quiet_cycles;
    int src_gap_pct;
    int sink_gap_pct;
    int hold_left;

    always #CLK_HALF clk = ~clk;

    // Status fields follow the phase after the word has been applied
    function automatic seq_report_t make_report(logic valid, logic [CHAR_W-1:0] ch,
                                                logic last, logic done);
        seq_report_t r;
        r.relay_drive = (seq_phase >= PH_RELAY) && (seq_phase <= PH_RELEASE);
        r.coil_drive  = (seq_phase == PH_POLARIZE);
        r.sampling_on = (seq_phase == PH_SAMPLING);
        r.phase       = seq_phase;
        r.char_valid  = valid;
        r.tx_char     = ch;
        r.last_of_run = last;
        r.run_done    = done;
        return r;
    endfunction

    // Apply one word to the mirror and queue the reports it causes;
    // returns 1 when the word does something beyond being ignored
    function automatic bit step_sequencer(logic [FUNC_W-1:0] f, logic [SAMPLE_W-1:0] s,
                                          logic [BYTE_W-1:0] b);
        logic [CNT_W-1:0]  limit;
        logic [CNT_W-1:0]  goal;
        logic [PAIR_W-1:0] pair_bits;
        logic [5:0]        code;
        bit                busy;
        logic              done;
        int                k;
        busy = 1'b0;
        done = 1'b0;
        case (f)
            FUNC_TICK:
                if (seq_phase >= PH_SETTLE && seq_phase <= PH_WAIT) begin
                    limit = wait_len[seq_phase - PH_SETTLE];
                    if (limit == '0)
                        limit = 16'd1;
                    if (tick_cnt != CNT_MAX)
                        tick_cnt = tick_cnt + 16'd1;
                    if (tick_cnt >= limit) begin
                        seq_phase = seq_phase + 3'd1;
                        tick_cnt  = '0;
                    end
                    busy = 1'b1;
                end
            FUNC_SAMPLE:
                if (seq_phase == PH_SAMPLING) begin
                    busy = 1'b1;
                    if (!odd_half) begin
                        first_half = s;
                        odd_half   = 1'b1;
                    end
                    else begin
                        pair_bits   = {first_half, s};
                        odd_half    = 1'b0;
                        pairs_taken = pairs_taken + 16'd1;
                        goal        = (run_pairs == '0) ? 16'd1 : run_pairs;
                        if (pairs_taken >= goal) begin
                            done        = 1'b1;
                            seq_phase   = PH_IDLE;
                            pairs_taken = '0;
                            tick_cnt    = '0;
                        end
                        // Four characters, most significant six bits first
                        for (k = 0; k < 4; k++) begin
                            code = pair_bits[PAIR_W-1-6*k -: 6];
                            due_reports.push_back(make_report(1'b1, 7'(b64_table[code]),
                                                              k == 3, done));
                        end
                        return busy;
                    end
                end
            FUNC_BYTE:
                if (seq_phase == PH_IDLE && b == START_BYTE) begin
                    seq_phase   = PH_SETTLE;
                    tick_cnt    = '0;
                    first_half  = '0;
                    odd_half    = 1'b0;
                    pairs_taken = '0;
                    busy        = 1'b1;
                end
            default: ;
        endcase
        due_reports.push_back(make_report(1'b0, '0, 1'b1, 1'b0));
        return busy;
    endfunction

    function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void check_report(seq_report_t got);
        seq_report_t want;
        if (due_reports.size() == 0) begin
            $display("%0t: result with nothing expected, expected none, actual %p", $time, got);
            mismatches++;
            return;
        end
        want = due_reports.pop_front();
        compare_field("relay_drive", want.relay_drive, got.relay_drive);
        compare_field("coil_drive", want.coil_drive, got.coil_drive);
        compare_field("sampling_on", want.sampling_on, got.sampling_on);
        compare_field("phase", want.phase, got.phase);
        compare_field("char_valid", want.char_valid, got.char_valid);
        compare_field("tx_char", want.tx_char, got.tx_char);
        compare_field("last_of_run", want.last_of_run, got.last_of_run);
        compare_field("run_done", want.run_done, got.run_done);
    endfunction

    // Clear the mirror in reset; afterwards predict on every accepted input
    // word and check every accepted result word
    always @(posedge clk) begin
        if (!rst_n) begin
            seq_phase   = PH_IDLE;
            tick_cnt    = '0;
            first_half  = '0;
            odd_half    = 1'b0;
            pairs_taken = '0;
            due_reports.delete();
        end
        else begin
            if (item_if.valid && item_if.ready) begin
                if (step_sequencer(item_if.func, item_if.sample, item_if.rx_byte))
                    busy_words++;
            end
            if (result_if.valid && result_if.ready)
                check_report('{result_if.relay_drive, result_if.coil_drive,
                               result_if.sampling_on, result_if.phase,
                               result_if.char_valid, result_if.tx_char,
                               result_if.last_of_run, result_if.run_done});
        end
    end

    // Receiver: random stalls, or a long hold-off on request
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            result_if.ready <= 1'b0;
            hold_left       <= 0;
        end
        else if (stall_req) begin
            result_if.ready <= 1'b0;
            hold_left       <= HOLD_CYCLES;
        end
        else if (hold_left != 0) begin
            result_if.ready <= 1'b0;
            hold_left       <= hold_left - 1;
        end
        else begin
            result_if.ready <= ($urandom_range(99) >= sink_gap_pct);
        end
    end

    // Drop the run when nothing moves for too long
    always @(posedge clk) begin
        if (!rst_n || cfg_we || (item_if.valid && item_if.ready)
            || (result_if.valid && result_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: timeout, no word accepted for %0d cycles", $time, quiet_cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Offer one word, with random gaps, and hold it until accepted
    task automatic send_word(logic [FUNC_W-1:0] f, logic [SAMPLE_W-1:0] s,
                             logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < src_gap_pct) begin
            item_if.valid <= 1'b0;
            @(posedge clk);
        end
        item_if.valid   <= 1'b1;
        item_if.func    <= f;
        item_if.sample  <= s;
        item_if.rx_byte <= b;
        @(posedge clk);
        while (!item_if.ready)
            @(posedge clk);
    endtask

    task automatic send_noise();
        logic [SAMPLE_W-1:0] s;
        logic [BYTE_W-1:0]   b;
        s = 12'($urandom);
        b = 8'($urandom_range(255));
        case ($urandom_range(3))
            0:       send_word(FUNC_TICK, s, b);
            1:       send_word(FUNC_SAMPLE, s, b);
            2:       send_word(FUNC_BYTE, s, b);
            default: send_word(FUNC_UNUSED, s, b);
        endcase
    endtask

    // Hold the input until every expected word is back
    task automatic pause_until_drained();
        item_if.valid <= 1'b0;
        @(posedge clk);
        while (due_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        if (idx == REG_PAIRS)
            run_pairs = val;
        else
            wait_len[idx] = val;
    endtask

    task automatic send_tick();
        send_word(FUNC_TICK, 12'($urandom), 8'($urandom));
    endtask

    task automatic send_sample(logic [SAMPLE_W-1:0] s);
        send_word(FUNC_SAMPLE, s, 8'($urandom));
    endtask

    task automatic send_byte(logic [BYTE_W-1:0] b);
        send_word(FUNC_BYTE, 12'($urandom), b);
    endtask

    // Reset settle length and pair count, ignored words in idle and in sampling
    task automatic test_default_timing();
        send_tick();
        send_sample(12'hABC);
        send_byte(START_BYTE ^ 8'h01);
        send_byte(START_BYTE | 8'h80);
        send_word(FUNC_UNUSED, 12'hFFF, 8'hFF);
        send_byte(START_BYTE);
        // Settle on the reset length, then shorten the remaining waits
        repeat (int'(RST_SETTLE)) send_tick();
        pause_until_drained();
        write_reg(REG_RELAY, 16'd1);
        write_reg(REG_POLARIZE, 16'd1);
        write_reg(REG_RELEASE, 16'd1);
        write_reg(REG_SAMPLE, 16'd1);
        repeat (4) send_tick();
        send_sample(12'h000);
        send_sample(12'h000);
        send_sample(12'hFFF);
        send_sample(12'hFFF);
        send_tick();
        send_byte(START_BYTE);
        send_word(FUNC_UNUSED, 12'h000, 8'h00);
        // Lower the pair count below what is already done: next pair ends the run
        pause_until_drained();
        write_reg(REG_PAIRS, 16'd1);
        send_sample(12'hFFF);
        send_sample(12'h000);
        send_sample(12'h123);
    endtask

    // Largest and zero settings, changed mid-run; every alphabet character
    task automatic test_register_extremes();
        logic [PAIR_W-1:0] sweep;
        int                k;
        pause_until_drained();
        for (k = 0; k < 5; k++)
            write_reg(WAIT_REGS[k], 16'hFFFF);
        write_reg(REG_PAIRS, 16'hFFFF);
        send_byte(START_BYTE);
        repeat (3) send_tick();
        pause_until_drained();
        write_reg(REG_SETTLE, 16'd0);
        write_reg(REG_RELAY, 16'd1);
        send_tick();
        send_tick();
        repeat (2) send_tick();
        pause_until_drained();
        write_reg(REG_POLARIZE, 16'd2);
        write_reg(REG_RELEASE, 16'd0);
        write_reg(REG_SAMPLE, 16'd1);
        repeat (3) send_tick();
        for (k = 0; k < 16; k++) begin
            sweep = {6'(4 * k), 6'(4 * k + 1), 6'(4 * k + 2), 6'(4 * k + 3)};
            send_sample(sweep[PAIR_W-1:SAMPLE_W]);
            send_sample(sweep[SAMPLE_W-1:0]);
        end
        pause_until_drained();
        write_reg(REG_PAIRS, 16'd0);
        send_sample(12'h5A5);
        send_sample(12'hA5A);
    endtask

    // Fill the block while the receiver holds off, then let it drain
    task automatic test_output_backpressure();
        int k;
        pause_until_drained();
        for (k = 0; k < 5; k++)
            write_reg(WAIT_REGS[k], 16'd1);
        write_reg(REG_PAIRS, 16'd12);
        send_byte(START_BYTE);
        repeat (5) send_tick();
        stall_req <= 1'b1;
        @(posedge clk);
        stall_req <= 1'b0;
        repeat (24) send_sample(12'($urandom));
        pause_until_drained();
    endtask

    // One run with short random settings; now and then cut short
    task automatic random_run();
        int ticks_left;
        int samples_left;
        int w;
        int pairs;
        int k;
        bit broken;
        pause_until_drained();
        ticks_left = 0;
        for (k = 0; k < 5; k++) begin
            w = $urandom_range(5);
            write_reg(WAIT_REGS[k], 16'(w));
            ticks_left += (w == 0) ? 1 : w;
        end
        pairs = $urandom_range(4);
        write_reg(REG_PAIRS, 16'(pairs));
        samples_left = 2 * ((pairs == 0) ? 1 : pairs);
        broken = ($urandom_range(9) == 0);
        if (broken) begin
            ticks_left   = $urandom_range(ticks_left);
            samples_left = $urandom_range(samples_left);
        end
        repeat ($urandom_range(2)) send_noise();
        send_byte(START_BYTE);
        while (ticks_left > 0) begin
            if ($urandom_range(5) == 0)
                send_noise();
            else begin
                send_tick();
                ticks_left--;
            end
        end
        while (samples_left > 0) begin
            if ($urandom_range(5) == 0)
                send_noise();
            else begin
                send_sample(12'($urandom));
                samples_left--;
            end
        end
    endtask

    task automatic test_random_traffic(int src_pct, int sink_pct);
        int goal;
        src_gap_pct  = src_pct;
        sink_gap_pct = sink_pct;
        goal = busy_words + RANDOM_SHARE;
        while (busy_words < goal)
            random_run();
    endtask

    initial begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        stall_req       = 1'b0;
        item_if.valid   = 1'b0;
        item_if.func    = FUNC_TICK;
        item_if.sample  = '0;
        item_if.rx_byte = '0;
        src_gap_pct     = 36;
        sink_gap_pct    = 88;
        wait_len[0]     = RST_SETTLE;
        wait_len[1]     = RST_RELAY;
        wait_len[2]     = RST_POLARIZE;
        wait_len[3]     = RST_RELEASE;
        wait_len[4]     = RST_SAMPLE;
        run_pairs       = RST_PAIRS;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_timing();
        test_register_extremes();
        test_output_backpressure();
        test_random_traffic(36, 88);
        test_random_traffic(88, 36);
        test_random_traffic(0, 0);
        pause_until_drained();

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
